>>> rtl/tle_pkg.sv
`default_nettype none

package tle_pkg;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] OP_KEY      = 2'd0;
    localparam logic [1:0] OP_TAKE     = 2'd1;
    localparam logic [1:0] OP_SET_MODE = 2'd2;

    // Line modes.
    localparam logic [1:0] MODE_CANON    = 2'd0;
    localparam logic [1:0] MODE_PASSWORD = 2'd1;
    localparam logic [1:0] MODE_RAW      = 2'd2;

    // Key bytes with a meaning of their own.
    localparam logic [7:0] KEY_CTRL   = 8'h1D;
    localparam logic [7:0] KEY_IGNORE = 8'hFF;
    localparam logic [7:0] KEY_NL     = 8'h0A;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_T      = 8'h74;
    localparam logic [7:0] KEY_C      = 8'h63;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAKE = 4'b0100,
        S_TAKE = 4'b1000
    } state_t;

    // Input tdata layout, first field in the highest bits.
    typedef struct packed {
        logic [3:0] pad;
        logic [1:0] new_mode;
        logic       reader_waiting;
        logic       swallow_key;
        logic [7:0] key_code;
    } in_item_t;

    // Output tdata layout, first field in the highest bits.
    typedef struct packed {
        logic       pad;
        logic [7:0] line_char;
        logic       line_valid;
        logic [1:0] active_terminal;
        logic       switched;
        logic       interrupt_foreground;
        logic       wake_reader;
        logic [7:0] echo_char;
        logic       echo_valid;
    } out_item_t;

    // What one key press does to the active line.
    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       canon_nl;
        logic       sw;
        logic       intr;
        logic       fill_inc;
        logic       fill_dec;
        logic       armed_next;
    } key_eff_t;

endpackage

`default_nettype wire

>>> rtl/tty_line_editor_core.sv
`default_nettype none

// Line editor for TERMINALS virtual terminals. Each request on the slave
// stream is a key press, a take-line or a set-mode (kind in tuser) that acts
// on the active terminal; the block takes one request at a time. A key press
// or set-mode gives one result, loaded into the output register (a
// ctrl-t key first passes through S_WAKE, which reads the new terminal's
// mode from the state memory a second time). A take-line streams the active
// line, one character per cycle while the output is free, from the line
// memory's single read port, and ends with tlast; an empty line gives a
// single result with line_valid low. The next request can be taken once
// the last result is in the output register, even while it still waits on
// m_axis_tready. Per-terminal fill counts and modes live in a small state
// memory whose entries read as zero until first written; line characters
// live in a TERMINALS x LINE_LENGTH byte memory.
module tty_line_editor_core #(
    parameter int TERMINALS   = 4,
    parameter int LINE_LENGTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // key_code[7:0], swallow_key[8], reader_waiting[9], new_mode[11:10], zero[15:12]
    input  wire logic [15:0] s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // echo_valid[0], echo_char[8:1], wake_reader[9], interrupt_foreground[10],
    // switched[11], active_terminal[13:12], line_valid[14], line_char[22:15], zero[23]
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    import tle_pkg::*;

    localparam int TW    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
    localparam int IW    = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
    localparam int FW    = $clog2(LINE_LENGTH + 1);
    localparam int SW    = FW + 2;
    localparam int DEPTH = TERMINALS * LINE_LENGTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t          state_reg, state_next;
    logic [TW-1:0]   active_reg, active_next;
    logic            armed_reg, armed_next;
    logic [TERMINALS-1:0] st_valid_reg, st_valid_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;
    logic            out_last_reg, out_last_next;
    logic [IW-1:0]   rd_idx_reg, rd_idx_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [1:0]      mode_reg, mode_next;
    logic [1:0]      op_reg;
    in_item_t        in_reg;

    logic            accept;
    logic            out_free;
    logic            load_out;

    logic            st_we;
    logic [SW-1:0]   st_wdata;
    logic [SW-1:0]   st_rdata;
    logic [SW-1:0]   st_cur;
    logic [1:0]      cur_mode;
    logic [FW-1:0]   cur_fill;

    logic            ln_we;
    logic [AW-1:0]   ln_waddr;
    logic [AW-1:0]   ln_raddr;
    logic [AW-1:0]   ln_base;
    logic [7:0]      ln_rdata;

    key_eff_t        ke;
    logic [TW-1:0]   next_term;
    logic [1:0]      clamp_mode;
    out_item_t       plain_item;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // An entry never written reads as canonical with an empty line.
    assign st_cur   = st_valid_reg[active_reg] ? st_rdata : '0;
    assign cur_mode = st_cur[SW-1:FW];
    assign cur_fill = st_cur[FW-1:0];

    assign ln_base   = AW'(AW'(active_reg) * LINE_LENGTH);
    assign ln_raddr  = ln_base + AW'(rd_idx_next);
    assign ln_waddr  = ln_base + AW'(cur_fill[IW-1:0]);
    assign next_term = (active_reg == TW'(TERMINALS - 1)) ? '0 : active_reg + 1'b1;
    assign clamp_mode = (in_reg.new_mode == 2'd3) ? MODE_RAW : in_reg.new_mode;

    always_comb
    begin
        plain_item = '0;
        plain_item.active_terminal = 2'(active_reg);
    end

    tle_key_edit #(
        .LINE_LENGTH (LINE_LENGTH)
    ) u_key_edit (
        .key_code    (in_reg.key_code),
        .swallow_key (in_reg.swallow_key),
        .mode        (cur_mode),
        .fill        (cur_fill),
        .armed       (armed_reg),
        .eff         (ke)
    );

    // Fill count and mode of each terminal; read at the next active index so
    // the entry is ready the cycle after a request is taken or a switch.
    tle_ram #(
        .WIDTH (SW),
        .DEPTH (TERMINALS)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (active_reg),
        .wdata (st_wdata),
        .raddr (active_next),
        .rdata (st_rdata)
    );

    tle_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (in_reg.key_code),
        .raddr (ln_raddr),
        .rdata (ln_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        armed_next     = armed_reg;
        rd_idx_next    = rd_idx_reg;
        fill_next      = fill_reg;
        mode_next      = mode_reg;
        load_out       = 1'b0;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        st_we          = 1'b0;
        st_wdata       = st_cur;
        ln_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_KEY:
                    begin
                        if (ke.sw)
                        begin
                            active_next = next_term;
                            armed_next  = ke.armed_next;
                            state_next  = S_WAKE;
                        end
                        else if (out_free)
                        begin
                            armed_next = ke.armed_next;
                            if (ke.fill_inc)
                            begin
                                ln_we    = 1'b1;
                                st_we    = 1'b1;
                                st_wdata = {cur_mode, cur_fill + 1'b1};
                            end
                            else if (ke.fill_dec)
                            begin
                                st_we    = 1'b1;
                                st_wdata = {cur_mode, cur_fill - 1'b1};
                            end
                            load_out      = 1'b1;
                            out_last_next = 1'b1;
                            out_data_next = plain_item;
                            out_data_next.echo_valid = ke.echo_valid;
                            out_data_next.echo_char  = ke.echo_char;
                            out_data_next.interrupt_foreground = ke.intr;
                            // A newline in canonical or password mode wakes only a waiting reader;
                            // otherwise a raw terminal is woken on every key.
                            out_data_next.wake_reader = ke.canon_nl ?
                                in_reg.reader_waiting :
                                (cur_mode != MODE_CANON && cur_mode != MODE_PASSWORD);
                            state_next = S_IDLE;
                        end
                    end
                    OP_TAKE:
                    begin
                        if (cur_fill == '0)
                        begin
                            if (out_free)
                            begin
                                load_out      = 1'b1;
                                out_last_next = 1'b1;
                                out_data_next = plain_item;
                                state_next    = S_IDLE;
                            end
                        end
                        else
                        begin
                            fill_next   = cur_fill;
                            mode_next   = cur_mode;
                            rd_idx_next = '0;
                            state_next  = S_TAKE;
                        end
                    end
                    OP_SET_MODE:
                    begin
                        if (out_free)
                        begin
                            st_we         = 1'b1;
                            st_wdata      = {clamp_mode, cur_fill};
                            load_out      = 1'b1;
                            out_last_next = 1'b1;
                            out_data_next = plain_item;
                            state_next    = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            load_out      = 1'b1;
                            out_last_next = 1'b1;
                            out_data_next = plain_item;
                            state_next    = S_IDLE;
                        end
                    end
                endcase
            end
            S_WAKE:
            begin
                if (out_free)
                begin
                    load_out      = 1'b1;
                    out_last_next = 1'b1;
                    out_data_next = plain_item;
                    out_data_next.switched    = 1'b1;
                    out_data_next.wake_reader =
                        (cur_mode != MODE_CANON && cur_mode != MODE_PASSWORD);
                    state_next = S_IDLE;
                end
            end
            S_TAKE:
            begin
                if (out_free)
                begin
                    load_out      = 1'b1;
                    out_data_next = plain_item;
                    out_data_next.line_valid = 1'b1;
                    out_data_next.line_char  = ln_rdata;
                    out_last_next = (FW'(rd_idx_reg) == fill_reg - 1'b1);
                    if (out_last_next)
                    begin
                        st_we      = 1'b1;
                        st_wdata   = {mode_reg, {FW{1'b0}}};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (st_we)
        begin
            st_valid_next[active_reg] = 1'b1;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            armed_reg     <= 1'b0;
            st_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            armed_reg     <= armed_next;
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= s_axis_tuser;
            in_reg <= s_axis_tdata;
        end
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        rd_idx_reg   <= rd_idx_next;
        fill_reg     <= fill_next;
        mode_reg     <= mode_next;
    end

`ifndef NO_ASSERTIONS
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("result loaded over an unsent result");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted request did not start execution");

    a_take_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAKE) |-> (FW'(rd_idx_reg) < fill_reg))
        else $error("line read beyond the fill count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> (st_wdata[FW-1:0] <= FW'(LINE_LENGTH)))
        else $error("fill count written beyond the line length");
`endif

endmodule

`default_nettype wire

>>> rtl/tle_ram.sv
`default_nettype none

module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/tle_key_edit.sv
`default_nettype none

module tle_key_edit #(
    parameter int LINE_LENGTH = 64
) (
    input  wire logic [7:0]                         key_code,
    input  wire logic                               swallow_key,
    input  wire logic [1:0]                         mode,
    input  wire logic [$clog2(LINE_LENGTH+1)-1:0]   fill,
    input  wire logic                               armed,
    output tle_pkg::key_eff_t                       eff
);
    import tle_pkg::*;

    localparam int FW = $clog2(LINE_LENGTH + 1);

    logic canon_like;
    logic pwd;

    assign canon_like = (mode == MODE_CANON) || (mode == MODE_PASSWORD);
    assign pwd        = (mode == MODE_PASSWORD);

    always_comb
    begin
        eff = '0;
        eff.armed_next = armed;
        if (!swallow_key)
        begin
            if (canon_like && key_code == KEY_NL)
            begin
                eff.echo_valid = 1'b1;
                eff.echo_char  = KEY_NL;
                eff.canon_nl   = 1'b1;
                eff.armed_next = 1'b0;
            end
            else if (key_code == KEY_NL || fill >= FW'(LINE_LENGTH))
            begin
                // A full line drops the key and just echoes a new line; a raw-mode newline does the same.
                eff.echo_valid = 1'b1;
                eff.echo_char  = KEY_NL;
                eff.armed_next = 1'b0;
            end
            else if (key_code == KEY_BS)
            begin
                if (fill != '0)
                begin
                    eff.fill_dec   = 1'b1;
                    eff.echo_valid = !pwd;
                    eff.echo_char  = pwd ? 8'h00 : KEY_BS;
                end
                eff.armed_next = 1'b0;
            end
            else if (key_code == KEY_CTRL)
            begin
                eff.armed_next = 1'b1;
            end
            else if (key_code == KEY_IGNORE)
            begin
                eff.armed_next = armed;
            end
            else if (armed && key_code == KEY_T)
            begin
                eff.sw         = 1'b1;
                eff.armed_next = 1'b0;
            end
            else if (armed && key_code == KEY_C)
            begin
                eff.intr       = 1'b1;
                eff.armed_next = 1'b0;
            end
            else
            begin
                eff.fill_inc   = 1'b1;
                eff.echo_valid = !pwd;
                eff.echo_char  = pwd ? 8'h00 : key_code;
                eff.armed_next = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
